@@ hdl/lsi_pkg.sv @@
`default_nettype none
package lsi_pkg;

    // Coordinate format.
    localparam int CW  = 16;            // coordinate width
    localparam int FRAC_BITS = 4;       // fraction bits, the scale cancels out of the geometry

    // Derived widths.
    localparam int DW  = CW + 1;        // coordinate difference
    localparam int PW  = 2 * DW;        // product of two differences
    localparam int SW  = PW + 1;        // difference of two such products
    localparam int CPW = 2 * CW;        // product of two coordinates
    localparam int CSW = CPW + 1;       // line constant c
    localparam int NPW = DW + CSW;      // difference times line constant
    localparam int NW  = NPW + 1;       // numerator of the intersection point
    localparam int QW  = CW + 1;        // quotient magnitude bits resolved by the divider
    localparam int RW  = ((NW > SW + QW) ? NW : SW + QW) + 1;  // remainder width

    localparam logic [QW-1:0] POS_LIMIT = QW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [QW-1:0] NEG_LIMIT = QW'(64'd1 << (CW - 1));

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [DW-1:0]  diff_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [SW-1:0]  sum_t;
    typedef logic signed [CPW-1:0] cprod_t;
    typedef logic signed [CSW-1:0] csum_t;
    typedef logic signed [NPW-1:0] nprod_t;
    typedef logic signed [NW-1:0]  num_t;
    typedef logic        [RW-1:0]  mag_t;
    typedef logic        [QW-1:0]  quo_t;
    typedef logic        [1:0]     op_t;
    typedef logic        [1:0]     cls_t;

    localparam op_t OP_LINE_LINE = 2'd0;
    localparam op_t OP_SEG_SEG   = 2'd1;
    localparam op_t OP_LINE_SEG  = 2'd2;
    localparam op_t OP_POINT     = 2'd3;

    localparam cls_t CLS_NONE = 2'd0;
    localparam cls_t CLS_HIT  = 2'd1;
    localparam cls_t CLS_EDGE = 2'd2;

    // Classification result that travels alongside the arithmetic.
    typedef struct packed {
        cls_t cls;
        logic pv;
    } res_info_t;

endpackage
`default_nettype wire

@@ hdl/lsi_front.sv @@
`default_nettype none
module lsi_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid_in,
    output logic                   ready_out,
    input  wire lsi_pkg::op_t      operation,
    input  wire lsi_pkg::coord_t   a1_x,
    input  wire lsi_pkg::coord_t   a1_y,
    input  wire lsi_pkg::coord_t   a2_x,
    input  wire lsi_pkg::coord_t   a2_y,
    input  wire lsi_pkg::coord_t   b1_x,
    input  wire lsi_pkg::coord_t   b1_y,
    input  wire lsi_pkg::coord_t   b2_x,
    input  wire lsi_pkg::coord_t   b2_y,
    output logic                   valid_out,
    input  wire logic              ready_in,
    output lsi_pkg::num_t          num_x,
    output lsi_pkg::num_t          num_y,
    output lsi_pkg::sum_t          denom,
    output lsi_pkg::res_info_t     info
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || ready_in;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign ready_out = rdy1;

    // Stage 1: differences and the bounding box test of the tested point.
    lsi_pkg::diff_t  s1_dax_reg, s1_day_reg, s1_bdx_reg, s1_bdy_reg;
    lsi_pkg::diff_t  s1_ex_reg, s1_ey_reg, s1_fx_reg, s1_fy_reg;
    lsi_pkg::coord_t s1_a1x_reg, s1_a1y_reg, s1_a2x_reg, s1_a2y_reg;
    lsi_pkg::coord_t s1_b1x_reg, s1_b1y_reg, s1_b2x_reg, s1_b2y_reg;
    lsi_pkg::op_t    s1_op_reg;
    logic            s1_out_reg;
    logic            out_next;

    always_comb
    begin
        out_next = (b1_x < a1_x && b1_x < a2_x) || (b1_x > a1_x && b1_x > a2_x) ||
                   (b1_y < a1_y && b1_y < a2_y) || (b1_y > a1_y && b1_y > a2_y);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_dax_reg <= lsi_pkg::diff_t'(a2_x) - lsi_pkg::diff_t'(a1_x);
            s1_day_reg <= lsi_pkg::diff_t'(a2_y) - lsi_pkg::diff_t'(a1_y);
            s1_bdx_reg <= lsi_pkg::diff_t'(b1_x) - lsi_pkg::diff_t'(b2_x);
            s1_bdy_reg <= lsi_pkg::diff_t'(b1_y) - lsi_pkg::diff_t'(b2_y);
            s1_ex_reg  <= lsi_pkg::diff_t'(b1_x) - lsi_pkg::diff_t'(a1_x);
            s1_ey_reg  <= lsi_pkg::diff_t'(b1_y) - lsi_pkg::diff_t'(a1_y);
            s1_fx_reg  <= lsi_pkg::diff_t'(b2_x) - lsi_pkg::diff_t'(a1_x);
            s1_fy_reg  <= lsi_pkg::diff_t'(b2_y) - lsi_pkg::diff_t'(a1_y);
            s1_a1x_reg <= a1_x;
            s1_a1y_reg <= a1_y;
            s1_a2x_reg <= a2_x;
            s1_a2y_reg <= a2_y;
            s1_b1x_reg <= b1_x;
            s1_b1y_reg <= b1_y;
            s1_b2x_reg <= b2_x;
            s1_b2y_reg <= b2_y;
            s1_op_reg  <= operation;
            s1_out_reg <= out_next;
        end
    end

    // Stage 2: all first-level products.
    lsi_pkg::prod_t  m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg, m8_reg;
    lsi_pkg::cprod_t c1a_reg, c1b_reg, c2a_reg, c2b_reg;
    lsi_pkg::diff_t  s2_dax_reg, s2_day_reg, s2_bdx_reg, s2_bdy_reg;
    lsi_pkg::op_t    s2_op_reg;
    logic            s2_out_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            m1_reg  <= lsi_pkg::prod_t'(s1_day_reg) * lsi_pkg::prod_t'(s1_bdx_reg);
            m2_reg  <= lsi_pkg::prod_t'(s1_dax_reg) * lsi_pkg::prod_t'(s1_bdy_reg);
            m3_reg  <= lsi_pkg::prod_t'(s1_ex_reg)  * lsi_pkg::prod_t'(s1_bdy_reg);
            m4_reg  <= lsi_pkg::prod_t'(s1_bdx_reg) * lsi_pkg::prod_t'(s1_ey_reg);
            m5_reg  <= lsi_pkg::prod_t'(s1_dax_reg) * lsi_pkg::prod_t'(s1_ey_reg);
            m6_reg  <= lsi_pkg::prod_t'(s1_ex_reg)  * lsi_pkg::prod_t'(s1_day_reg);
            m7_reg  <= lsi_pkg::prod_t'(s1_day_reg) * lsi_pkg::prod_t'(s1_fx_reg);
            m8_reg  <= lsi_pkg::prod_t'(s1_dax_reg) * lsi_pkg::prod_t'(s1_fy_reg);
            c1a_reg <= lsi_pkg::cprod_t'(s1_a1y_reg) * lsi_pkg::cprod_t'(s1_a2x_reg);
            c1b_reg <= lsi_pkg::cprod_t'(s1_a1x_reg) * lsi_pkg::cprod_t'(s1_a2y_reg);
            c2a_reg <= lsi_pkg::cprod_t'(s1_b1y_reg) * lsi_pkg::cprod_t'(s1_b2x_reg);
            c2b_reg <= lsi_pkg::cprod_t'(s1_b1x_reg) * lsi_pkg::cprod_t'(s1_b2y_reg);
            s2_dax_reg <= s1_dax_reg;
            s2_day_reg <= s1_day_reg;
            s2_bdx_reg <= s1_bdx_reg;
            s2_bdy_reg <= s1_bdy_reg;
            s2_op_reg  <= s1_op_reg;
            s2_out_reg <= s1_out_reg;
        end
    end

    // Stage 3: determinants and line constants.
    lsi_pkg::sum_t  hz_reg, ua_reg, ub_reg, d2_reg;
    lsi_pkg::csum_t c1_reg, c2_reg;
    lsi_pkg::diff_t s3_dax_reg, s3_day_reg, s3_bdx_reg, s3_bdy_reg;
    lsi_pkg::op_t   s3_op_reg;
    logic           s3_out_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            hz_reg <= lsi_pkg::sum_t'(m1_reg) - lsi_pkg::sum_t'(m2_reg);
            ua_reg <= lsi_pkg::sum_t'(m3_reg) - lsi_pkg::sum_t'(m4_reg);
            ub_reg <= lsi_pkg::sum_t'(m5_reg) - lsi_pkg::sum_t'(m6_reg);
            d2_reg <= lsi_pkg::sum_t'(m7_reg) - lsi_pkg::sum_t'(m8_reg);
            c1_reg <= lsi_pkg::csum_t'(c1a_reg) - lsi_pkg::csum_t'(c1b_reg);
            c2_reg <= lsi_pkg::csum_t'(c2a_reg) - lsi_pkg::csum_t'(c2b_reg);
            s3_dax_reg <= s2_dax_reg;
            s3_day_reg <= s2_day_reg;
            s3_bdx_reg <= s2_bdx_reg;
            s3_bdy_reg <= s2_bdy_reg;
            s3_op_reg  <= s2_op_reg;
            s3_out_reg <= s2_out_reg;
        end
    end

    // Stage 4: numerator products and classification.
    lsi_pkg::nprod_t   p1_reg, p2_reg, p3_reg, p4_reg;
    lsi_pkg::sum_t     s4_hz_reg;
    lsi_pkg::res_info_t s4_info_reg;
    lsi_pkg::res_info_t info_next;

    always_comb
    begin
        logic          flip;
        lsi_pkg::sum_t dn, uan, ubn;
        logic          hit, d1_pos, d1_neg, d2_pos, d2_neg;

        // The segment test wants a positive denominator, which is minus hz.
        flip = !hz_reg[lsi_pkg::SW-1] && (hz_reg != '0);
        dn   = flip ? hz_reg  : -hz_reg;
        uan  = flip ? -ua_reg : ua_reg;
        ubn  = flip ? -ub_reg : ub_reg;
        hit  = (dn != '0) && !uan[lsi_pkg::SW-1] && (uan <= dn) &&
               !ubn[lsi_pkg::SW-1] && (ubn <= dn);
        // The side of the first endpoint of B is minus ub.
        d1_pos = ub_reg[lsi_pkg::SW-1];
        d1_neg = !ub_reg[lsi_pkg::SW-1] && (ub_reg != '0);
        d2_pos = !d2_reg[lsi_pkg::SW-1] && (d2_reg != '0);
        d2_neg = d2_reg[lsi_pkg::SW-1];

        info_next.cls = lsi_pkg::CLS_NONE;
        info_next.pv  = 1'b0;
        case (s3_op_reg)
            lsi_pkg::OP_LINE_LINE:
            begin
                info_next.pv  = (hz_reg != '0);
                info_next.cls = (hz_reg != '0) ? lsi_pkg::CLS_HIT : lsi_pkg::CLS_NONE;
            end
            lsi_pkg::OP_SEG_SEG:
            begin
                if (hit)
                begin
                    info_next.pv  = 1'b1;
                    info_next.cls = (uan == '0 || uan == dn || ubn == '0 || ubn == dn) ?
                                    lsi_pkg::CLS_EDGE : lsi_pkg::CLS_HIT;
                end
            end
            lsi_pkg::OP_LINE_SEG:
            begin
                if (!((d1_pos && d2_pos) || (d1_neg && d2_neg)))
                begin
                    info_next.pv  = (hz_reg != '0);
                    info_next.cls = (ub_reg == '0 || d2_reg == '0) ?
                                    lsi_pkg::CLS_EDGE : lsi_pkg::CLS_HIT;
                end
            end
            lsi_pkg::OP_POINT:
            begin
                if (ub_reg == '0)
                begin
                    info_next.cls = s3_out_reg ? lsi_pkg::CLS_EDGE : lsi_pkg::CLS_HIT;
                end
            end
            default:
            begin
                info_next.cls = lsi_pkg::CLS_NONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            p1_reg <= lsi_pkg::nprod_t'(s3_dax_reg) * lsi_pkg::nprod_t'(c2_reg);
            p2_reg <= lsi_pkg::nprod_t'(c1_reg)     * lsi_pkg::nprod_t'(s3_bdx_reg);
            p3_reg <= lsi_pkg::nprod_t'(c1_reg)     * lsi_pkg::nprod_t'(s3_bdy_reg);
            p4_reg <= lsi_pkg::nprod_t'(s3_day_reg) * lsi_pkg::nprod_t'(c2_reg);
            s4_hz_reg   <= hz_reg;
            s4_info_reg <= info_next;
        end
    end

    // Stage 5: numerators of the intersection point.
    lsi_pkg::num_t      nx_reg, ny_reg;
    lsi_pkg::sum_t      s5_hz_reg;
    lsi_pkg::res_info_t s5_info_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            nx_reg <= -(lsi_pkg::num_t'(p1_reg) + lsi_pkg::num_t'(p2_reg));
            ny_reg <= -(lsi_pkg::num_t'(p3_reg) + lsi_pkg::num_t'(p4_reg));
            s5_hz_reg   <= s4_hz_reg;
            s5_info_reg <= s4_info_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= valid_in;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    assign valid_out = v5_reg;
    assign num_x     = nx_reg;
    assign num_y     = ny_reg;
    assign denom     = s5_hz_reg;
    assign info      = s5_info_reg;

endmodule
`default_nettype wire

@@ hdl/lsi_divider.sv @@
`default_nettype none
module lsi_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid_in,
    output logic                    ready_out,
    input  wire lsi_pkg::num_t      num_x,
    input  wire lsi_pkg::num_t      num_y,
    input  wire lsi_pkg::sum_t      denom,
    input  wire lsi_pkg::res_info_t info_in,
    output logic                    valid_out,
    input  wire logic               ready_in,
    output lsi_pkg::quo_t           quo_x,
    output lsi_pkg::quo_t           quo_y,
    output logic                    neg_x,
    output logic                    neg_y,
    output logic                    ovf_x,
    output logic                    ovf_y,
    output lsi_pkg::res_info_t      info_out
);

    localparam int NS = lsi_pkg::QW + 1;   // magnitude stage plus one stage per quotient bit

    logic               v_reg    [0:NS-1];
    logic               rdy      [0:NS];
    lsi_pkg::mag_t      rem_reg  [0:NS-1][0:1];
    lsi_pkg::quo_t      quo_reg  [0:NS-1][0:1];
    logic               neg_reg  [0:NS-1][0:1];
    logic               ovf_reg  [0:NS-1][0:1];
    lsi_pkg::mag_t      dmag_reg [0:NS-1];
    lsi_pkg::res_info_t info_reg [0:NS-1];

    assign rdy[NS] = ready_in;

    // Magnitude stage: restoring division works on magnitudes and fixes the sign at the end.
    assign rdy[0] = !v_reg[0] || rdy[1];

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rem_reg[0][0] <= lsi_pkg::mag_t'(num_x[lsi_pkg::NW-1] ? -num_x : num_x);
            rem_reg[0][1] <= lsi_pkg::mag_t'(num_y[lsi_pkg::NW-1] ? -num_y : num_y);
            dmag_reg[0]   <= lsi_pkg::mag_t'(denom[lsi_pkg::SW-1] ? -denom : denom);
            neg_reg[0][0] <= (num_x[lsi_pkg::NW-1] ^ denom[lsi_pkg::SW-1]) && (num_x != '0);
            neg_reg[0][1] <= (num_y[lsi_pkg::NW-1] ^ denom[lsi_pkg::SW-1]) && (num_y != '0);
            quo_reg[0][0] <= '0;
            quo_reg[0][1] <= '0;
            ovf_reg[0][0] <= 1'b0;
            ovf_reg[0][1] <= 1'b0;
            info_reg[0]   <= info_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (rdy[0])
        begin
            v_reg[0] <= valid_in;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar k = 1; k < NS; k++)
    begin : g_step
        localparam int B = lsi_pkg::QW - k;

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            lsi_pkg::mag_t sub;
            logic          ge;
            logic          ovf_next;
            lsi_pkg::quo_t quo_next;

            always_comb
            begin
                sub      = dmag_reg[k-1] << B;
                ge       = rem_reg[k-1][l] >= sub;
                quo_next = quo_reg[k-1][l];
                quo_next[B] = ge;
                if (k == 1)
                begin
                    ovf_next = rem_reg[k-1][l] >= (dmag_reg[k-1] << lsi_pkg::QW);
                end
                else
                begin
                    ovf_next = ovf_reg[k-1][l];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k])
                begin
                    rem_reg[k][l] <= ge ? (rem_reg[k-1][l] - sub) : rem_reg[k-1][l];
                    quo_reg[k][l] <= quo_next;
                    neg_reg[k][l] <= neg_reg[k-1][l];
                    ovf_reg[k][l] <= ovf_next;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                dmag_reg[k] <= dmag_reg[k-1];
                info_reg[k] <= info_reg[k-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign ready_out = rdy[0];
    assign valid_out = v_reg[NS-1];
    assign quo_x     = quo_reg[NS-1][0];
    assign quo_y     = quo_reg[NS-1][1];
    assign neg_x     = neg_reg[NS-1][0];
    assign neg_y     = neg_reg[NS-1][1];
    assign ovf_x     = ovf_reg[NS-1][0];
    assign ovf_y     = ovf_reg[NS-1][1];
    assign info_out  = info_reg[NS-1];

endmodule
`default_nettype wire

@@ hdl/line_segment_intersection_unit.sv @@
// An accepted input item passes the front-end stages, the divider stages and the output register.
// Throughput: one item per cycle while out_stall is low; the restoring divider (a magnitude
// stage and 17 stages of one quotient bit each) sets the depth; every stage holds its own item.
// A stall holds the output and each full stage behind it; earlier stages keep filling bubbles.
// Reset (rst_n, asynchronous, active low) empties the pipeline; no item survives it.
`default_nettype none
module line_segment_intersection_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire lsi_pkg::op_t    operation,
    input  wire lsi_pkg::coord_t a1_x,
    input  wire lsi_pkg::coord_t a1_y,
    input  wire lsi_pkg::coord_t a2_x,
    input  wire lsi_pkg::coord_t a2_y,
    input  wire lsi_pkg::coord_t b1_x,
    input  wire lsi_pkg::coord_t b1_y,
    input  wire lsi_pkg::coord_t b2_x,
    input  wire lsi_pkg::coord_t b2_y,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output lsi_pkg::cls_t        hit_class,
    output logic                 point_valid,
    output lsi_pkg::coord_t      cross_x,
    output lsi_pkg::coord_t      cross_y
);

    // The front end forms the differences, the cross products that decide the class,
    // and the two numerators of the exact intersection point over the common
    // denominator. The divider then resolves the quotient one bit per stage.
    logic               fe_valid, fe_ready;
    lsi_pkg::num_t      fe_num_x, fe_num_y;
    lsi_pkg::sum_t      fe_denom;
    lsi_pkg::res_info_t fe_info;

    logic               dv_valid, dv_ready;
    lsi_pkg::quo_t      dv_quo_x, dv_quo_y;
    logic               dv_neg_x, dv_neg_y, dv_ovf_x, dv_ovf_y;
    lsi_pkg::res_info_t dv_info;

    logic               in_ready;

    lsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .ready_out (in_ready),
        .operation (operation),
        .a1_x      (a1_x),
        .a1_y      (a1_y),
        .a2_x      (a2_x),
        .a2_y      (a2_y),
        .b1_x      (b1_x),
        .b1_y      (b1_y),
        .b2_x      (b2_x),
        .b2_y      (b2_y),
        .valid_out (fe_valid),
        .ready_in  (fe_ready),
        .num_x     (fe_num_x),
        .num_y     (fe_num_y),
        .denom     (fe_denom),
        .info      (fe_info)
    );

    lsi_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (fe_valid),
        .ready_out (fe_ready),
        .num_x     (fe_num_x),
        .num_y     (fe_num_y),
        .denom     (fe_denom),
        .info_in   (fe_info),
        .valid_out (dv_valid),
        .ready_in  (dv_ready),
        .quo_x     (dv_quo_x),
        .quo_y     (dv_quo_y),
        .neg_x     (dv_neg_x),
        .neg_y     (dv_neg_y),
        .ovf_x     (dv_ovf_x),
        .ovf_y     (dv_ovf_y),
        .info_out  (dv_info)
    );

    // Output register. The quotient is truncated toward zero already; here it gets its
    // sign and is clamped to the coordinate range. A result without a point reads as zero.
    logic            out_valid_reg;
    lsi_pkg::cls_t   cls_reg;
    logic            pv_reg;
    lsi_pkg::coord_t cx_reg, cy_reg;
    lsi_pkg::coord_t cx_next, cy_next;

    function automatic lsi_pkg::coord_t saturate(input lsi_pkg::quo_t q, input logic neg,
                                                 input logic ovf);
        lsi_pkg::coord_t r;
        if (neg)
        begin
            if (ovf || q > lsi_pkg::NEG_LIMIT)
                r = lsi_pkg::coord_t'(-lsi_pkg::NEG_LIMIT);
            else
                r = lsi_pkg::coord_t'(-q);
        end
        else
        begin
            if (ovf || q > lsi_pkg::POS_LIMIT)
                r = lsi_pkg::coord_t'(lsi_pkg::POS_LIMIT);
            else
                r = lsi_pkg::coord_t'(q);
        end
        return r;
    endfunction

    always_comb
    begin
        cx_next = dv_info.pv ? saturate(dv_quo_x, dv_neg_x, dv_ovf_x) : '0;
        cy_next = dv_info.pv ? saturate(dv_quo_y, dv_neg_y, dv_ovf_y) : '0;
    end

    assign dv_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (dv_ready)
        begin
            cls_reg <= dv_info.cls;
            pv_reg  <= dv_info.pv;
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dv_ready)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    assign in_stall    = !in_ready;
    assign out_valid   = out_valid_reg;
    assign hit_class   = cls_reg;
    assign point_valid = pv_reg;
    assign cross_x     = cx_reg;
    assign cross_y     = cy_reg;

endmodule
`default_nettype wire

@@ hdl/lsi_checker.sv @@
`default_nettype none
module lsi_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire lsi_pkg::cls_t   hit_class,
    input wire logic            point_valid,
    input wire lsi_pkg::coord_t cross_x,
    input wire lsi_pkg::coord_t cross_y
);

    // A stalled item stays on the output unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit_class) && $stable(point_valid)
                                   && $stable(cross_x) && $stable(cross_y))
        else $error("stalled output item changed");

    // Without a point the coordinates read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> cross_x == '0 && cross_y == '0)
        else $error("coordinates not cleared without a point");

    // A point is only reported together with a hit or an edge class.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> hit_class == lsi_pkg::CLS_HIT ||
                                     hit_class == lsi_pkg::CLS_EDGE)
        else $error("point reported without a hit");

    // The unused class code never appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hit_class == lsi_pkg::CLS_NONE || hit_class == lsi_pkg::CLS_HIT ||
                      hit_class == lsi_pkg::CLS_EDGE)
        else $error("undefined class code");

endmodule

bind line_segment_intersection_unit lsi_checker u_lsi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit_class   (hit_class),
    .point_valid (point_valid),
    .cross_x     (cross_x),
    .cross_y     (cross_y)
);
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int HALF_PERIOD = 4;
    localparam int LATENCY     = 24;
    localparam int CYCLE_LIMIT = 400000;

    // A directed row carries the item and, where it is obvious, the result.
    typedef struct {
        lsi_pkg::op_t    op;
        lsi_pkg::coord_t c [8];
        logic            known;
        lsi_pkg::cls_t   cls;
        logic            pv;
        lsi_pkg::coord_t rx;
        lsi_pkg::coord_t ry;
    } seg_row_t;

    typedef struct {
        lsi_pkg::cls_t   cls;
        logic            pv;
        lsi_pkg::coord_t rx;
        lsi_pkg::coord_t ry;
    } crossing_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    lsi_pkg::op_t    operation = lsi_pkg::OP_LINE_LINE;
    lsi_pkg::coord_t a1_x = '0, a1_y = '0, a2_x = '0, a2_y = '0;
    lsi_pkg::coord_t b1_x = '0, b1_y = '0, b2_x = '0, b2_y = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    lsi_pkg::cls_t   hit_class;
    logic            point_valid;
    lsi_pkg::coord_t cross_x, cross_y;

    crossing_t pending_crossings[$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        src_idle_pct = 0;
    int        dst_idle_pct = 0;
    int        hold_off_cycles = 0;
    seg_row_t  rows[$];

    line_segment_intersection_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation),
        .a1_x(a1_x), .a1_y(a1_y), .a2_x(a2_x), .a2_y(a2_y),
        .b1_x(b1_x), .b1_y(b1_y), .b2_x(b2_x), .b2_y(b2_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit_class(hit_class), .point_valid(point_valid),
        .cross_x(cross_x), .cross_y(cross_y)
    );

    always #HALF_PERIOD clk = ~clk;

    // Runaway guard: the slowest honest run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    endtask

    // Signed division truncating toward zero, clamped to the coordinate range.
    function automatic lsi_pkg::coord_t clamp_quotient(input longint n, input longint d);
        longint q;
        q = n / d;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return lsi_pkg::coord_t'(q);
    endfunction

    // Meeting point of the infinite lines p and q; returns 0 when they are parallel.
    function automatic logic meet_lines(input longint px1, py1, px2, py2,
                                        input longint qx1, qy1, qx2, qy2,
                                        output lsi_pkg::coord_t mx,
                                        output lsi_pkg::coord_t my);
        longint la, lb, lc, ma, mb, mc, det;
        la = py2 - py1; lb = px1 - px2; lc = py1 * px2 - px1 * py2;
        ma = qy2 - qy1; mb = qx1 - qx2; mc = qy1 * qx2 - qx1 * qy2;
        det = la * mb - lb * ma;
        mx = '0;
        my = '0;
        if (det == 0)
            return 1'b0;
        mx = clamp_quotient(lb * mc - lc * mb, det);
        my = clamp_quotient(lc * ma - la * mc, det);
        return 1'b1;
    endfunction

    // Predicts the result of one item from its operation and eight coordinates.
    function automatic crossing_t predict_crossing(input lsi_pkg::op_t op,
                                                   input lsi_pkg::coord_t c [8]);
        crossing_t r;
        longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, dx, dy;
        longint den, ua, ub, d1, d2, cr;
        logic outx, outy;
        ax1 = c[0]; ay1 = c[1]; ax2 = c[2]; ay2 = c[3];
        bx1 = c[4]; by1 = c[5]; bx2 = c[6]; by2 = c[7];
        dx = ax2 - ax1;
        dy = ay2 - ay1;
        r.cls = lsi_pkg::CLS_NONE; r.pv = 1'b0; r.rx = '0; r.ry = '0;
        case (op)
            lsi_pkg::OP_LINE_LINE:
            begin
                r.pv = meet_lines(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, r.rx, r.ry);
                r.cls = r.pv ? lsi_pkg::CLS_HIT : lsi_pkg::CLS_NONE;
            end
            lsi_pkg::OP_SEG_SEG:
            begin
                den = dx * (by1 - by2) - (bx1 - bx2) * dy;
                ua = (bx1 - ax1) * (by1 - by2) - (bx1 - bx2) * (by1 - ay1);
                ub = dx * (by1 - ay1) - (bx1 - ax1) * dy;
                if (den < 0)
                begin
                    den = -den; ua = -ua; ub = -ub;
                end
                if (den != 0 && ua >= 0 && ua <= den && ub >= 0 && ub <= den)
                begin
                    r.pv = meet_lines(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, r.rx, r.ry);
                    r.cls = (ua == 0 || ua == den || ub == 0 || ub == den) ?
                            lsi_pkg::CLS_EDGE : lsi_pkg::CLS_HIT;
                end
            end
            lsi_pkg::OP_LINE_SEG:
            begin
                d1 = dy * (bx1 - ax1) - dx * (by1 - ay1);
                d2 = dy * (bx2 - ax1) - dx * (by2 - ay1);
                if (!((d1 > 0 && d2 > 0) || (d1 < 0 && d2 < 0)))
                begin
                    r.pv = meet_lines(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, r.rx, r.ry);
                    r.cls = (d1 == 0 || d2 == 0) ? lsi_pkg::CLS_EDGE : lsi_pkg::CLS_HIT;
                end
            end
            default:
            begin
                cr = dx * (by1 - ay1) - dy * (bx1 - ax1);
                if (cr == 0)
                begin
                    outx = (bx1 < ax1 && bx1 < ax2) || (bx1 > ax1 && bx1 > ax2);
                    outy = (by1 < ay1 && by1 < ay2) || (by1 > ay1 && by1 > ay2);
                    r.cls = (outx || outy) ? lsi_pkg::CLS_EDGE : lsi_pkg::CLS_HIT;
                end
            end
        endcase
        if (!r.pv)
        begin
            r.rx = '0;
            r.ry = '0;
        end
        return r;
    endfunction

    function automatic seg_row_t make_row(input lsi_pkg::op_t op,
                                          input int x1, y1, x2, y2, x3, y3, x4, y4);
        seg_row_t r;
        r.op = op;
        r.c[0] = lsi_pkg::coord_t'(x1); r.c[1] = lsi_pkg::coord_t'(y1);
        r.c[2] = lsi_pkg::coord_t'(x2); r.c[3] = lsi_pkg::coord_t'(y2);
        r.c[4] = lsi_pkg::coord_t'(x3); r.c[5] = lsi_pkg::coord_t'(y3);
        r.c[6] = lsi_pkg::coord_t'(x4); r.c[7] = lsi_pkg::coord_t'(y4);
        r.known = 1'b0;
        r.cls = lsi_pkg::CLS_NONE; r.pv = 1'b0; r.rx = '0; r.ry = '0;
        return r;
    endfunction

    function automatic seg_row_t known_row(input seg_row_t r, input lsi_pkg::cls_t cls,
                                           input logic pv, input int rx, input int ry);
        r.known = 1'b1;
        r.cls = cls; r.pv = pv; r.rx = lsi_pkg::coord_t'(rx); r.ry = lsi_pkg::coord_t'(ry);
        return r;
    endfunction

    // Random coordinate: mostly small values so that hits and touches happen,
    // sometimes the full range so that saturation and every bit are reached.
    function automatic lsi_pkg::coord_t rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return lsi_pkg::coord_t'($urandom);
            2:       return ($urandom_range(0, 1) != 0) ? lsi_pkg::coord_t'(16'sh7fff) :
                                                          lsi_pkg::coord_t'(16'sh8000);
            default: return lsi_pkg::coord_t'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    // Builds a random item; many are shaped so that B lands on A, shares its endpoint or runs parallel.
    function automatic seg_row_t rand_row();
        seg_row_t r;
        int k, t;
        r = make_row(lsi_pkg::op_t'($urandom_range(0, 3)), 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 8; i++)
            r.c[i] = rand_coord();
        k = $urandom_range(0, 5);
        t = $signed($urandom_range(0, 6)) - 2;
        if (k == 0)
        begin
            // B1 on the line through A at an integer step along it.
            r.c[4] = lsi_pkg::coord_t'(r.c[0] + t * (r.c[2] - r.c[0]));
            r.c[5] = lsi_pkg::coord_t'(r.c[1] + t * (r.c[3] - r.c[1]));
        end
        else if (k == 1)
        begin
            // B shares an endpoint with A.
            r.c[6] = r.c[2];
            r.c[7] = r.c[3];
        end
        else if (k == 2)
        begin
            // B parallel to A.
            r.c[6] = lsi_pkg::coord_t'(r.c[4] + r.c[2] - r.c[0]);
            r.c[7] = lsi_pkg::coord_t'(r.c[5] + r.c[3] - r.c[1]);
        end
        return r;
    endfunction

    task automatic offer_item(input seg_row_t r);
        crossing_t e;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= r.op;
        a1_x <= r.c[0]; a1_y <= r.c[1]; a2_x <= r.c[2]; a2_y <= r.c[3];
        b1_x <= r.c[4]; b1_y <= r.c[5]; b2_x <= r.c[6]; b2_y <= r.c[7];
        do
            @(posedge clk);
        while (in_stall);
        if (r.known)
        begin
            e.cls = r.cls; e.pv = r.pv; e.rx = r.rx; e.ry = r.ry;
        end
        else
            e = predict_crossing(r.op, r.c);
        pending_crossings.push_back(e);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_crossings.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < dst_idle_pct);
    end

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        crossing_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_crossings.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                e = pending_crossings.pop_front();
                if (hit_class !== e.cls)
                    report_mismatch("hit_class", hit_class, e.cls);
                if (point_valid !== e.pv)
                    report_mismatch("point_valid", point_valid, e.pv);
                if (cross_x !== e.rx)
                    report_mismatch("cross_x", cross_x, e.rx);
                if (cross_y !== e.ry)
                    report_mismatch("cross_y", cross_y, e.ry);
            end
        end
    end

    initial
    begin
        int stretch;
        // Directed table: extremes, every operation and the listed corner cases.
        rows.push_back(known_row(make_row(lsi_pkg::OP_LINE_LINE, 0, 0, 16, 0, 0, 0, 0, 16),
                                 lsi_pkg::CLS_HIT, 1'b1, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_LINE_LINE, 0, 0, 16, 0, 0, 16, 16, 16),
                                 lsi_pkg::CLS_NONE, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_LINE_LINE, 5, 5, 5, 5, 0, 0, 0, 16),
                                 lsi_pkg::CLS_NONE, 1'b0, 0, 0));
        rows.push_back(make_row(lsi_pkg::OP_LINE_LINE, -32768, -32768, 32767, 32767,
                                -32768, 32767, 32767, -32768));
        // Nearly parallel lines: the meeting point lies at the edge of the coordinate range.
        rows.push_back(make_row(lsi_pkg::OP_LINE_LINE, 0, 0, 32767, 1, 0, 1, 32767, 1));
        rows.push_back(make_row(lsi_pkg::OP_LINE_LINE, 0, 0, -32768, 1, 0, -1, -32768, 1));
        rows.push_back(known_row(make_row(lsi_pkg::OP_SEG_SEG, -16, 0, 16, 0, 0, -16, 0, 16),
                                 lsi_pkg::CLS_HIT, 1'b1, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_SEG_SEG, 0, 0, 16, 0, 16, 0, 16, 16),
                                 lsi_pkg::CLS_EDGE, 1'b1, 16, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_SEG_SEG, 0, 0, 16, 0, 32, 0, 48, 0),
                                 lsi_pkg::CLS_NONE, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_SEG_SEG, 0, 0, 16, 0, 0, 16, 16, 16),
                                 lsi_pkg::CLS_NONE, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_SEG_SEG, 0, 0, 16, 0, 32, -16, 32, 16),
                                 lsi_pkg::CLS_NONE, 1'b0, 0, 0));
        rows.push_back(make_row(lsi_pkg::OP_SEG_SEG, -32768, -32768, 32767, 32767,
                                -32768, 32767, 32767, -32768));
        rows.push_back(known_row(make_row(lsi_pkg::OP_LINE_SEG, 0, 0, 16, 0, 100, -16, 100, 16),
                                 lsi_pkg::CLS_HIT, 1'b1, 100, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_LINE_SEG, 0, 0, 16, 0, 50, 0, 50, 16),
                                 lsi_pkg::CLS_EDGE, 1'b1, 50, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_LINE_SEG, 0, 0, 16, 0, 32, 0, 64, 0),
                                 lsi_pkg::CLS_EDGE, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_LINE_SEG, 7, 7, 7, 7, 1, 2, 3, 4),
                                 lsi_pkg::CLS_EDGE, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_LINE_SEG, 0, 0, 16, 0, 0, 16, 16, 32),
                                 lsi_pkg::CLS_NONE, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_POINT, 0, 0, 32, 32, 16, 16, 0, 0),
                                 lsi_pkg::CLS_HIT, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_POINT, 0, 0, 32, 32, 48, 48, 0, 0),
                                 lsi_pkg::CLS_EDGE, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_POINT, 0, 0, 32, 32, 16, 17, 0, 0),
                                 lsi_pkg::CLS_NONE, 1'b0, 0, 0));
        // Vertical segment: the point lies on the line but beyond it in y.
        rows.push_back(known_row(make_row(lsi_pkg::OP_POINT, 8, 0, 8, 16, 8, 40, -1, -1),
                                 lsi_pkg::CLS_EDGE, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_POINT, 3, 3, 3, 3, 3, 3, 0, 0),
                                 lsi_pkg::CLS_HIT, 1'b0, 0, 0));
        rows.push_back(known_row(make_row(lsi_pkg::OP_POINT, 3, 3, 3, 3, 9, -9, 0, 0),
                                 lsi_pkg::CLS_EDGE, 1'b0, 0, 0));
        rows.push_back(make_row(lsi_pkg::OP_POINT, 32767, 32767, -32768, -32768,
                                -32768, -32768, 32767, -32768));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            offer_item(rows[i]);

        // Random part in three phases of differing idle rates, then a pressure phase.
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 70 : 0;
            dst_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 29 : 0;
            for (int n = 0; n < 170; n++)
                offer_item(rand_row());
            // Sender pauses until the pipeline has delivered everything.
            drain_results();
        end

        // Long receiver hold-off while items keep coming, to fill the pipe.
        src_idle_pct = 0;
        dst_idle_pct = 10;
        hold_off_cycles = 60;
        for (int n = 0; n < 80; n++)
            offer_item(rand_row());

        drain_results();
        stretch = 0;
        while (stretch < LATENCY * 4)
        begin
            @(negedge clk);
            stretch++;
        end

        if (error_count == 0 && pending_crossings.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/lsi_pkg.sv
hdl/lsi_front.sv
hdl/lsi_divider.sv
hdl/line_segment_intersection_unit.sv
hdl/lsi_checker.sv
sim/tb.sv
